// ----- src/fdev_pkg.sv -----
`default_nettype none

package fdev_pkg;

    // Slave tdata layout, lowest bit first
    localparam int unsigned NameHeadW  = 64;
    localparam int unsigned NameTailW  = 24;
    localparam int unsigned AttrW      = 8;
    localparam int unsigned ClusterW   = 16;
    localparam int unsigned SizeW      = 32;
    localparam int unsigned NameBytes  = 11;
    localparam int unsigned NameW      = NameBytes * 8;

    localparam int unsigned NameHeadLo = 0;
    localparam int unsigned NameTailLo = NameHeadLo + NameHeadW;
    localparam int unsigned AttrLo     = NameTailLo + NameTailW;
    localparam int unsigned ClLowLo    = AttrLo + AttrW;
    localparam int unsigned ClHighLo   = ClLowLo + ClusterW;
    localparam int unsigned SizeLo     = ClHighLo + ClusterW;
    localparam int unsigned InDataW    = SizeLo + SizeW;
    localparam int unsigned OutDataW   = 8;

    // Name byte codes
    localparam logic [7:0] CH_FREE     = 8'h00;
    localparam logic [7:0] CH_DELETED  = 8'hE5;
    localparam logic [7:0] CH_E5_ALIAS = 8'h05;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PIPE     = 8'h7C;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    // Long-name order byte: high nibble must be one of these
    localparam logic [3:0] LFN_SEQ_PLAIN = 4'h0;
    localparam logic [3:0] LFN_SEQ_LAST  = 4'h4;

    // Attribute codes
    localparam logic [7:0] ATTR_RESERVED  = 8'hC0;
    localparam logic [7:0] ATTR_VOLUME    = 8'h08;
    localparam logic [7:0] ATTR_DIRECTORY = 8'h10;
    localparam logic [7:0] ATTR_LONGNAME  = 8'h0F;

    // "." and ".." padded with spaces, byte 0 in the low bits
    localparam logic [NameW-1:0] NAME_DOT    = {{(NameBytes-1){CH_SPACE}}, CH_DOT};
    localparam logic [NameW-1:0] NAME_DOTDOT = {{(NameBytes-2){CH_SPACE}}, CH_DOT, CH_DOT};

    typedef struct packed {
        logic is_dotdot;
        logic is_dot;
        logic entry_ok;
    } result_t;

    function automatic logic forbidden_char(input logic [7:0] c);
        return (c == CH_QUOTE) || (c == CH_PIPE)
            || ((c >= CH_STAR) && (c <= CH_COMMA))
            || ((c >= CH_DOT) && (c <= CH_SLASH))
            || ((c >= CH_COLON) && (c <= CH_QMARK))
            || ((c >= CH_LBRACKET) && (c <= CH_RBRACKET));
    endfunction

endpackage

`default_nettype wire

// ----- src/fat_dir_entry_validator_unit.sv -----
`default_nettype none

// Two register stages: an accepted entry waits in the input register while it is
// checked, and moves to the result register once that is free or being read.
// Throughput: one entry per cycle while m_tready stays high; the input register and
// the result register each hold one transaction, and all checks fit between them.
// Reset (rst_n low, asynchronous) empties both registers; the block holds no
// other state.

module fat_dir_entry_validator_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // name_head[63:0], name_tail[87:64], attribute_byte[95:88], cluster_low[111:96],
    // cluster_high[127:112], size_bytes[159:128]
    input  wire logic [fdev_pkg::InDataW-1:0]  s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // entry_ok[0], is_dot[1], is_dotdot[2], zero fill [7:3]
    output logic [fdev_pkg::OutDataW-1:0]      m_tdata,
    output logic                               m_tlast
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic [fdev_pkg::InDataW-1:0]  in_data_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    fdev_pkg::result_t             out_res_reg;
    logic                          out_last_reg;
    fdev_pkg::result_t             res;
    logic                          out_free;
    logic                          advance;
    logic                          s_fire;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;

    fdev_check u_check (
        .name_head      (in_data_reg[fdev_pkg::NameHeadLo +: fdev_pkg::NameHeadW]),
        .name_tail      (in_data_reg[fdev_pkg::NameTailLo +: fdev_pkg::NameTailW]),
        .attribute_byte (in_data_reg[fdev_pkg::AttrLo +: fdev_pkg::AttrW]),
        .cluster_low    (in_data_reg[fdev_pkg::ClLowLo +: fdev_pkg::ClusterW]),
        .cluster_high   (in_data_reg[fdev_pkg::ClHighLo +: fdev_pkg::ClusterW]),
        .size_bytes     (in_data_reg[fdev_pkg::SizeLo +: fdev_pkg::SizeW]),
        .result         (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance)
        begin
            out_res_reg  <= res;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fdev_pkg::OutDataW - $bits(fdev_pkg::result_t)){1'b0}}, out_res_reg};
    assign m_tlast  = out_last_reg;

    a_dots_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_res_reg.is_dot && out_res_reg.is_dotdot))
        else $error("dot and dot-dot flagged together");

    a_dots_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_res_reg.is_dot || out_res_reg.is_dotdot)) |-> out_res_reg.entry_ok)
        else $error("dot entry judged invalid");

    a_free_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ((in_data_reg[7:0] == fdev_pkg::CH_FREE)
                     || (in_data_reg[7:0] == fdev_pkg::CH_DELETED)))
        |=> (out_valid_reg && out_res_reg.entry_ok))
        else $error("free or deleted entry judged invalid");

    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_valid_reg && (out_last_reg == $past(in_last_reg))))
        else $error("transaction lost between input and result register");

endmodule

`default_nettype wire

// ----- src/fdev_check.sv -----
`default_nettype none

module fdev_check (
    input  wire logic [fdev_pkg::NameHeadW-1:0] name_head,
    input  wire logic [fdev_pkg::NameTailW-1:0] name_tail,
    input  wire logic [fdev_pkg::AttrW-1:0]     attribute_byte,
    input  wire logic [fdev_pkg::ClusterW-1:0]  cluster_low,
    input  wire logic [fdev_pkg::ClusterW-1:0]  cluster_high,
    input  wire logic [fdev_pkg::SizeW-1:0]     size_bytes,
    output fdev_pkg::result_t                   result
);

    logic [fdev_pkg::NameW-1:0]     name;
    logic [7:0]                     b0;
    logic [fdev_pkg::NameBytes-1:0] byte_bad;
    logic                           scan_ok;
    logic                           dot1;
    logic                           dot2;
    logic                           size_zero;
    logic                           ok;

    assign name      = {name_tail, name_head};
    assign b0        = name[7:0];
    assign dot1      = (name == fdev_pkg::NAME_DOT);
    assign dot2      = (name == fdev_pkg::NAME_DOTDOT);
    assign size_zero = (size_bytes == '0);

    always_comb
    begin
        logic [7:0] c;
        c = '0;
        for (int i = 0; i < int'(fdev_pkg::NameBytes); i++)
        begin
            c = name[i*8 +: 8];
            if (c < fdev_pkg::CH_SPACE)
            begin
                byte_bad[i] = !((i == 0) && (c == fdev_pkg::CH_E5_ALIAS));
            end
            else if (c == fdev_pkg::CH_SPACE)
            begin
                byte_bad[i] = (i == 0);
            end
            else
            begin
                byte_bad[i] = fdev_pkg::forbidden_char(c);
            end
        end
    end

    assign scan_ok = ~|byte_bad;

    // Rules apply in priority order; the first that decides wins
    always_comb
    begin
        if ((b0 == fdev_pkg::CH_FREE) || (b0 == fdev_pkg::CH_DELETED))
        begin
            ok = 1'b1;
        end
        else if ((attribute_byte & fdev_pkg::ATTR_RESERVED) != '0)
        begin
            ok = 1'b0;
        end
        else if (attribute_byte == fdev_pkg::ATTR_LONGNAME)
        begin
            ok = (b0[7:4] == fdev_pkg::LFN_SEQ_PLAIN) || (b0[7:4] == fdev_pkg::LFN_SEQ_LAST);
        end
        else if ((attribute_byte & fdev_pkg::ATTR_LONGNAME) == fdev_pkg::ATTR_LONGNAME)
        begin
            ok = 1'b0;
        end
        else if (((attribute_byte & fdev_pkg::ATTR_VOLUME) != '0)
                 && ((attribute_byte != fdev_pkg::ATTR_VOLUME)
                     || (cluster_low != '0) || (cluster_high != '0)))
        begin
            ok = 1'b0;
        end
        else if ((attribute_byte & fdev_pkg::ATTR_DIRECTORY) != '0)
        begin
            ok = size_zero && (dot1 || dot2 || scan_ok);
        end
        else
        begin
            ok = scan_ok;
        end
    end

    assign result.entry_ok  = ok;
    assign result.is_dot    = (attribute_byte == fdev_pkg::ATTR_DIRECTORY) && size_zero && dot1;
    assign result.is_dotdot = (attribute_byte == fdev_pkg::ATTR_DIRECTORY) && size_zero && dot2;

endmodule

`default_nettype wire

// ----- tb/tb_fat_dir_entry_validator_unit.sv -----
`default_nettype none

module tb_fat_dir_entry_validator_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ATTR_READONLY = 8'h01;
    localparam logic [7:0] ATTR_HIDDEN   = 8'h02;
    localparam logic [7:0] ATTR_SYSTEM   = 8'h04;
    localparam logic [7:0] ATTR_ARCHIVE  = 8'h20;
    localparam logic [7:0] ATTR_RSVD_LO  = 8'h40;
    localparam logic [7:0] ATTR_RSVD_HI  = 8'h80;

    typedef logic [fdev_pkg::NameW-1:0] name_t;

    typedef struct {
        name_t                         name;
        logic [fdev_pkg::AttrW-1:0]    attr;
        logic [fdev_pkg::ClusterW-1:0] clo;
        logic [fdev_pkg::ClusterW-1:0] chi;
        logic [fdev_pkg::SizeW-1:0]    entry_size;
        logic                          last_flag;
    } dir_entry_t;

    typedef struct {
        logic entry_ok;
        logic is_dot;
        logic is_dotdot;
        logic last_flag;
    } verdict_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [fdev_pkg::InDataW-1:0]  s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [fdev_pkg::OutDataW-1:0] m_tdata;
    logic                          m_tlast;

    verdict_t pending_verdicts[$];
    int       error_count = 0;
    bit       tx_gaps = 1'b0;
    bit       rx_gaps = 1'b0;
    int       rx_hold_cycles = 0;

    fat_dir_entry_validator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit is_punct(input logic [7:0] c);
        return (c == fdev_pkg::CH_QUOTE) || (c == fdev_pkg::CH_PIPE)
            || (c >= fdev_pkg::CH_STAR && c <= fdev_pkg::CH_COMMA)
            || (c == fdev_pkg::CH_DOT) || (c == fdev_pkg::CH_SLASH)
            || (c >= fdev_pkg::CH_COLON && c <= fdev_pkg::CH_QMARK)
            || (c >= fdev_pkg::CH_LBRACKET && c <= fdev_pkg::CH_RBRACKET);
    endfunction

    // Work out validity and the dot flags of one directory entry
    function automatic verdict_t judge_entry(input dir_entry_t e);
        verdict_t   v;
        logic [7:0] nb [fdev_pkg::NameBytes];
        logic [7:0] c;
        bit         one_dot;
        bit         two_dots;
        bit         scan_ok;
        bit         plain_dir;
        for (int i = 0; i < fdev_pkg::NameBytes; i++)
            nb[i] = e.name[8*i +: 8];
        one_dot  = 1'b1;
        two_dots = 1'b1;
        scan_ok  = 1'b1;
        for (int i = 0; i < fdev_pkg::NameBytes; i++)
        begin
            c = nb[i];
            if (c != ((i < 1) ? fdev_pkg::CH_DOT : fdev_pkg::CH_SPACE))
                one_dot = 1'b0;
            if (c != ((i < 2) ? fdev_pkg::CH_DOT : fdev_pkg::CH_SPACE))
                two_dots = 1'b0;
            if (c < fdev_pkg::CH_SPACE)
            begin
                if (!(i == 0 && c == fdev_pkg::CH_E5_ALIAS))
                    scan_ok = 1'b0;
            end
            else if (c == fdev_pkg::CH_SPACE)
            begin
                if (i == 0)
                    scan_ok = 1'b0;
            end
            else if (is_punct(c))
                scan_ok = 1'b0;
        end

        if (nb[0] == fdev_pkg::CH_FREE || nb[0] == fdev_pkg::CH_DELETED)
            v.entry_ok = 1'b1;
        else if ((e.attr & fdev_pkg::ATTR_RESERVED) != 0)
            v.entry_ok = 1'b0;
        else if ((e.attr & fdev_pkg::ATTR_LONGNAME) == fdev_pkg::ATTR_LONGNAME
                 && e.attr != fdev_pkg::ATTR_LONGNAME)
            v.entry_ok = 1'b0;
        else if (e.attr == fdev_pkg::ATTR_LONGNAME)
            v.entry_ok = (nb[0][7:4] == fdev_pkg::LFN_SEQ_PLAIN)
                         || (nb[0][7:4] == fdev_pkg::LFN_SEQ_LAST);
        else if ((e.attr & fdev_pkg::ATTR_VOLUME) != 0
                 && (e.attr != fdev_pkg::ATTR_VOLUME || e.clo != 0 || e.chi != 0))
            v.entry_ok = 1'b0;
        else if ((e.attr & fdev_pkg::ATTR_DIRECTORY) != 0 && e.entry_size != 0)
            v.entry_ok = 1'b0;
        else if ((e.attr & fdev_pkg::ATTR_DIRECTORY) != 0 && (one_dot || two_dots))
            v.entry_ok = 1'b1;
        else
            v.entry_ok = scan_ok;

        plain_dir   = (e.attr == fdev_pkg::ATTR_DIRECTORY) && (e.entry_size == 0);
        v.is_dot    = plain_dir && one_dot;
        v.is_dotdot = plain_dir && two_dots;
        v.last_flag = e.last_flag;
        return v;
    endfunction

    function automatic name_t text_name(input string s);
        name_t n;
        for (int i = 0; i < fdev_pkg::NameBytes; i++)
            n[8*i +: 8] = (i < s.len()) ? s[i] : fdev_pkg::CH_SPACE;
        return n;
    endfunction

    function automatic name_t with_byte(input name_t n, input int idx, input logic [7:0] c);
        n[8*idx +: 8] = c;
        return n;
    endfunction

    function automatic name_t random_name();
        return name_t'({$urandom, $urandom, $urandom});
    endfunction

    function automatic dir_entry_t make_entry(input name_t n, input logic [7:0] attr,
                                              input logic [15:0] clo, input logic [15:0] chi,
                                              input logic [31:0] entry_size,
                                              input logic last_flag);
        dir_entry_t e;
        e.name       = n;
        e.attr       = attr;
        e.clo        = clo;
        e.chi        = chi;
        e.entry_size = entry_size;
        e.last_flag  = last_flag;
        return e;
    endfunction

    // Mostly well-formed short names and attributes, with noise mixed in
    function automatic dir_entry_t random_entry();
        dir_entry_t e;
        logic [7:0] c;
        int         name_len;
        case ($urandom_range(0, 9))
            0: e.name = random_name();
            1: e.name = $urandom_range(0, 1) ? fdev_pkg::NAME_DOT : fdev_pkg::NAME_DOTDOT;
            default:
            begin
                name_len = int'($urandom_range(1, fdev_pkg::NameBytes));
                for (int i = 0; i < fdev_pkg::NameBytes; i++)
                begin
                    c = 8'($urandom_range(33, 255));
                    while (is_punct(c))
                        c = 8'($urandom_range(33, 255));
                    e.name[8*i +: 8] = (i < name_len) ? c : fdev_pkg::CH_SPACE;
                end
            end
        endcase
        case ($urandom_range(0, 11))
            0: e.name = with_byte(e.name, 0, fdev_pkg::CH_FREE);
            1: e.name = with_byte(e.name, 0, fdev_pkg::CH_DELETED);
            2: e.name = with_byte(e.name, 0, fdev_pkg::CH_E5_ALIAS);
            3: e.name = with_byte(e.name, 0, fdev_pkg::CH_SPACE);
            4: e.name = with_byte(e.name, int'($urandom_range(0, fdev_pkg::NameBytes - 1)),
                                  8'($urandom_range(0, 255)));
            default: ;
        endcase
        case ($urandom_range(0, 7))
            0: e.attr = 8'($urandom_range(0, 255));
            1: e.attr = fdev_pkg::ATTR_LONGNAME;
            2: e.attr = fdev_pkg::ATTR_VOLUME;
            3: e.attr = fdev_pkg::ATTR_DIRECTORY;
            4: e.attr = fdev_pkg::ATTR_DIRECTORY | (8'($urandom_range(0, 255))
                        & (ATTR_READONLY | ATTR_HIDDEN | ATTR_SYSTEM | ATTR_ARCHIVE));
            default: e.attr = 8'($urandom_range(0, 255))
                              & ~(fdev_pkg::ATTR_RESERVED | fdev_pkg::ATTR_VOLUME);
        endcase
        if (e.attr == fdev_pkg::ATTR_LONGNAME && $urandom_range(0, 1))
            e.name[7:4] = $urandom_range(0, 1) ? fdev_pkg::LFN_SEQ_LAST : fdev_pkg::LFN_SEQ_PLAIN;
        e.clo        = $urandom_range(0, 1) ? 16'($urandom) : '0;
        e.chi        = $urandom_range(0, 1) ? 16'($urandom) : '0;
        e.entry_size = $urandom_range(0, 1) ? $urandom : '0;
        e.last_flag  = 1'($urandom_range(0, 1));
        return e;
    endfunction

    task automatic send_entry(input dir_entry_t e);
        logic [fdev_pkg::InDataW-1:0] word;
        word = '0;
        word[fdev_pkg::NameHeadLo +: fdev_pkg::NameW]  = e.name;
        word[fdev_pkg::AttrLo +: fdev_pkg::AttrW]      = e.attr;
        word[fdev_pkg::ClLowLo +: fdev_pkg::ClusterW]  = e.clo;
        word[fdev_pkg::ClHighLo +: fdev_pkg::ClusterW] = e.chi;
        word[fdev_pkg::SizeLo +: fdev_pkg::SizeW]      = e.entry_size;
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tdata  <= word;
        s_tlast  <= e.last_flag;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_verdicts.push_back(judge_entry(e));
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic flag_mismatch(input string field, input logic expv, input logic actv);
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, expv, actv);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata %h tlast %0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                v = pending_verdicts.pop_front();
                if (m_tdata[0] !== v.entry_ok)
                    flag_mismatch("entry_ok", v.entry_ok, m_tdata[0]);
                if (m_tdata[1] !== v.is_dot)
                    flag_mismatch("is_dot", v.is_dot, m_tdata[1]);
                if (m_tdata[2] !== v.is_dotdot)
                    flag_mismatch("is_dotdot", v.is_dotdot, m_tdata[2]);
                if (m_tlast !== v.last_flag)
                    flag_mismatch("last_out", v.last_flag, m_tlast);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (rx_gaps && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic test_directed_cases();
        name_t base_name;
        base_name = text_name("FILE    TXT");
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // free and deleted entries pass whatever else they hold; reserved attribute bits fail
        send_entry(make_entry(with_byte('1, 0, fdev_pkg::CH_FREE), 8'hFF, '1, '1, '1, 1'b1));
        send_entry(make_entry(with_byte(random_name(), 0, fdev_pkg::CH_DELETED),
                              fdev_pkg::ATTR_RESERVED, '1, '1, '1, 1'b0));
        send_entry(make_entry(base_name, ATTR_ARCHIVE, 16'h0002, '0, 32'd1234, 1'b0));
        send_entry(make_entry(base_name, ATTR_RSVD_LO, '0, '0, '0, 1'b1));
        send_entry(make_entry(base_name, ATTR_RSVD_HI, '0, '0, '0, 1'b0));
        // long-name entries
        send_entry(make_entry(with_byte(random_name(), 0, 8'h01), fdev_pkg::ATTR_LONGNAME,
                              '1, '1, '1, 1'b0));
        send_entry(make_entry(with_byte(random_name(), 0, 8'h45), fdev_pkg::ATTR_LONGNAME,
                              '0, '0, '0, 1'b0));
        send_entry(make_entry(with_byte(random_name(), 0, 8'h21), fdev_pkg::ATTR_LONGNAME,
                              '0, '0, '0, 1'b1));
        send_entry(make_entry(with_byte(base_name, 0, 8'h41),
                              fdev_pkg::ATTR_LONGNAME | fdev_pkg::ATTR_DIRECTORY,
                              '0, '0, '0, 1'b0));
        // volume labels
        send_entry(make_entry(text_name("VOLUME"), fdev_pkg::ATTR_VOLUME, '0, '0, '1, 1'b0));
        send_entry(make_entry(text_name("VOLUME"), fdev_pkg::ATTR_VOLUME, 16'h0001, '0, '0,
                              1'b0));
        send_entry(make_entry(text_name("VOLUME"), fdev_pkg::ATTR_VOLUME, '0, 16'h8000, '0,
                              1'b0));
        send_entry(make_entry(text_name("VOLUME"), fdev_pkg::ATTR_VOLUME | ATTR_ARCHIVE,
                              '0, '0, '0, 1'b0));
        // directories, dot and dot-dot
        send_entry(make_entry(text_name("SUBDIR"), fdev_pkg::ATTR_DIRECTORY, 16'h1234, '0, '0,
                              1'b0));
        send_entry(make_entry(text_name("SUBDIR"), fdev_pkg::ATTR_DIRECTORY, '0, '0, 32'd1,
                              1'b0));
        send_entry(make_entry(fdev_pkg::NAME_DOT, fdev_pkg::ATTR_DIRECTORY, 16'h0005, '0, '0,
                              1'b0));
        send_entry(make_entry(fdev_pkg::NAME_DOTDOT, fdev_pkg::ATTR_DIRECTORY, '1, '1, '0,
                              1'b1));
        send_entry(make_entry(fdev_pkg::NAME_DOT, fdev_pkg::ATTR_DIRECTORY | ATTR_ARCHIVE,
                              '0, '0, '0, 1'b0));
        send_entry(make_entry(fdev_pkg::NAME_DOT, '0, '0, '0, '0, 1'b0));
        send_entry(make_entry(fdev_pkg::NAME_DOTDOT, fdev_pkg::ATTR_DIRECTORY, '0, '0, 32'd5,
                              1'b0));
        // name scan
        send_entry(make_entry(with_byte(base_name, 0, fdev_pkg::CH_E5_ALIAS), ATTR_ARCHIVE,
                              '0, '0, '0, 1'b0));
        send_entry(make_entry(with_byte(base_name, 4, fdev_pkg::CH_E5_ALIAS), ATTR_ARCHIVE,
                              '0, '0, '0, 1'b0));
        send_entry(make_entry(with_byte(base_name, 0, fdev_pkg::CH_SPACE), '0, '0, '0, '0,
                              1'b0));
        send_entry(make_entry(with_byte(base_name, 10, 8'h1F), '0, '0, '0, '0, 1'b0));
        send_entry(make_entry(with_byte(with_byte(with_byte(base_name, 1, 8'h7F), 2, 8'h80),
                              9, 8'hFF), ATTR_READONLY, '0, '0, '0, 1'b0));
        send_entry(make_entry(with_byte(base_name, 3, fdev_pkg::CH_QUOTE), '0, '0, '0, '0,
                              1'b0));
        send_entry(make_entry(with_byte(base_name, 8, fdev_pkg::CH_PIPE), '0, '0, '0, '0,
                              1'b0));
        send_entry(make_entry(with_byte(base_name, 6, fdev_pkg::CH_LBRACKET), '0, '0, '0, '0,
                              1'b1));
        drain_results();
    endtask

    task automatic test_random_traffic();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        repeat (1000) send_entry(random_entry());
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        rx_hold_cycles = 300;
        repeat (40) send_entry(random_entry());
        drain_results();
    endtask

    task automatic test_streaming_no_idle();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        repeat (150) send_entry(random_entry());
        drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();
        test_streaming_no_idle();
        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- fat_dir_entry_validator_unit.f -----
src/fdev_pkg.sv
src/fdev_check.sv
src/fat_dir_entry_validator_unit.sv
tb/tb_fat_dir_entry_validator_unit.sv
